@@ rtl/core/vrba_pkg.sv @@
package vrba_pkg;

    // Default parameter values for the top level.
    localparam int DEF_ITERATIONS = 16;
    localparam int DEF_FRAC_BITS  = 16;

    // Guard bits carried below the output LSB through the CORDIC cells.
    localparam int GUARD = 8;

    // Width of the x and y datapath inside the cells: the 32-bit result, the guard bits,
    // and headroom for the quadrant fold and the intermediate growth of the iterations.
    localparam int XY_W = 32 + GUARD + 3;

    // 2^64 / (2*pi), rounded.
    localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;

    // atan(2^-i) in units of 2^-32 turn.
    localparam logic [31:0] ATAN_TURN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
        32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
    };

    // Payload handed from one CORDIC cell to the next.
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [31:0]     z;
    } xyz_t;

    // Square of the CORDIC gain in Q2.30, accumulated over the iterations.
    function automatic logic [63:0] vrba_gain_p(input int iters);
        logic [63:0] p;
        p = 64'd1 << 30;
        for (int i = 0; i < 32; i++) begin
            if (i < iters && 2 * i < 31) begin
                p = p + (p >> (2 * i));
            end
        end
        return p;
    endfunction

    // Floor of the square root of a 64-bit value, one result bit per step.
    function automatic logic [63:0] vrba_isqrt(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bval;
        n    = n_in;
        res  = 64'd0;
        bval = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (n >= res + bval) begin
                n   = n - (res + bval);
                res = (res >> 1) + bval;
            end else begin
                res = res >> 1;
            end
            bval = bval >> 2;
        end
        return res;
    endfunction

endpackage

@@ rtl/core/vrba_front.sv @@
module vrba_front #(
    parameter int ITERATIONS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                valid_i,
    input  logic signed [31:0]  x_in,
    input  logic signed [31:0]  y_in,
    input  logic signed [31:0]  angle,
    input  logic                angle_in_radians,
    output logic                ready_o,
    output logic                valid_o,
    output vrba_pkg::xyz_t      data_o,
    input  logic                ready_i
);
    import vrba_pkg::*;

    localparam int NSTAGE = 5;

    // Angle-to-phase factors for both units, one turn being 2^32.
    localparam logic [63:0] KD = ((64'd1 << (64 - FRAC_BITS)) + 64'd180) / 64'd360;
    localparam logic [63:0] KR = (INV_TWO_PI_Q64 + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;

    // Gain compensation factor in Q0.32.
    localparam logic [63:0] GAIN_S = vrba_isqrt(vrba_gain_p(ITERATIONS) << 32);
    localparam logic [63:0] GAIN   = ((64'd1 << 63) + GAIN_S / 64'd2) / GAIN_S;

    localparam logic [63:0]        PHASE_ROUND = 64'h0000_0000_8000_0000;
    localparam logic [31:0]        QUAD_ROUND  = 32'h2000_0000;
    localparam logic signed [65:0] PRE_ROUND   = 66'sd1 <<< (31 - GUARD);

    // Quadrant codes.
    localparam logic [1:0] QUAD_0   = 2'd0;
    localparam logic [1:0] QUAD_90  = 2'd1;
    localparam logic [1:0] QUAD_180 = 2'd2;
    localparam logic [1:0] QUAD_270 = 2'd3;

    // Per-stage occupancy and the ready chain that lets bubbles collapse.
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] stage_rdy;

    always_comb begin
        stage_rdy[NSTAGE-1] = !valid_reg[NSTAGE-1] || ready_i;
        for (int j = NSTAGE - 2; j >= 0; j--) begin
            stage_rdy[j] = !valid_reg[j] || stage_rdy[j+1];
        end
    end

    assign ready_o = stage_rdy[0];
    assign valid_o = valid_reg[NSTAGE-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_rdy[0]) begin
                valid_reg[0] <= valid_i;
            end
            for (int j = 1; j < NSTAGE; j++) begin
                if (stage_rdy[j]) begin
                    valid_reg[j] <= valid_reg[j-1];
                end
            end
        end
    end

    // Stage 1: angle times the unit factor, split on the factor's two 32-bit halves.
    logic [63:0]        k_sel;
    logic signed [64:0] pp0_full;
    logic [63:0]        pp1_full;
    logic [63:0]        pp0_reg;
    logic [31:0]        pp1_reg;
    logic signed [31:0] x1_reg;
    logic signed [31:0] y1_reg;

    assign k_sel    = angle_in_radians ? KR : KD;
    assign pp0_full = angle * $signed({1'b0, k_sel[31:0]});
    assign pp1_full = {32'd0, angle} * {32'd0, k_sel[63:32]};

    always_ff @(posedge aclk) begin
        if (stage_rdy[0]) begin
            pp0_reg <= pp0_full[63:0];
            pp1_reg <= pp1_full[31:0];
            x1_reg  <= x_in;
            y1_reg  <= y_in;
        end
    end

    // Stage 2: combine the partial products modulo 2^64 and round to a 32-bit phase.
    logic [63:0]        phase_sum;
    logic [31:0]        phase_reg;
    logic signed [31:0] x2_reg;
    logic signed [31:0] y2_reg;

    assign phase_sum = pp0_reg + {pp1_reg, 32'd0} + PHASE_ROUND;

    always_ff @(posedge aclk) begin
        if (stage_rdy[1]) begin
            phase_reg <= phase_sum[63:32];
            x2_reg    <= x1_reg;
            y2_reg    <= y1_reg;
        end
    end

    // Stage 3: fold to the nearest quadrant and pre-rotate by a multiple of 90 degrees.
    logic [31:0]        quad_sum;
    logic [1:0]         quad;
    logic [31:0]        resid;
    logic signed [32:0] xe;
    logic signed [32:0] ye;
    logic signed [32:0] x3_next;
    logic signed [32:0] y3_next;
    logic signed [32:0] x3_reg;
    logic signed [32:0] y3_reg;
    logic signed [31:0] z3_reg;

    assign quad_sum = phase_reg + QUAD_ROUND;
    assign quad     = quad_sum[31:30];
    assign resid    = phase_reg - {quad, 30'd0};
    assign xe       = {x2_reg[31], x2_reg};
    assign ye       = {y2_reg[31], y2_reg};

    always_comb begin
        unique case (quad)
            QUAD_0: begin
                x3_next = xe;
                y3_next = ye;
            end
            QUAD_90: begin
                x3_next = -ye;
                y3_next = xe;
            end
            QUAD_180: begin
                x3_next = -xe;
                y3_next = -ye;
            end
            QUAD_270: begin
                x3_next = ye;
                y3_next = -xe;
            end
            default: begin
                x3_next = xe;
                y3_next = ye;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stage_rdy[2]) begin
            x3_reg <= x3_next;
            y3_reg <= y3_next;
            z3_reg <= $signed(resid);
        end
    end

    // Stage 4: apply the gain compensation.
    logic signed [65:0] xp_next;
    logic signed [65:0] yp_next;
    logic signed [65:0] xp_reg;
    logic signed [65:0] yp_reg;
    logic signed [31:0] z4_reg;

    assign xp_next = x3_reg * $signed({1'b0, GAIN[31:0]});
    assign yp_next = y3_reg * $signed({1'b0, GAIN[31:0]});

    always_ff @(posedge aclk) begin
        if (stage_rdy[3]) begin
            xp_reg <= xp_next;
            yp_reg <= yp_next;
            z4_reg <= z3_reg;
        end
    end

    // Stage 5: round away all but the guard bits.
    logic signed [65:0] xs;
    logic signed [65:0] ys;
    xyz_t               data_reg;

    assign xs = (xp_reg + PRE_ROUND) >>> (32 - GUARD);
    assign ys = (yp_reg + PRE_ROUND) >>> (32 - GUARD);

    always_ff @(posedge aclk) begin
        if (stage_rdy[4]) begin
            data_reg.x <= $signed(xs[XY_W-1:0]);
            data_reg.y <= $signed(ys[XY_W-1:0]);
            data_reg.z <= z4_reg;
        end
    end

    assign data_o = data_reg;

endmodule

@@ rtl/core/vrba_cell.sv @@
module vrba_cell #(
    parameter int SHIFT = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           valid_i,
    input  vrba_pkg::xyz_t data_i,
    output logic           ready_o,
    output logic           valid_o,
    output vrba_pkg::xyz_t data_o,
    input  logic           ready_i
);
    import vrba_pkg::*;

    localparam logic [4:0] IDX = 5'(SHIFT);

    logic                   valid_reg;
    xyz_t                   data_reg;
    xyz_t                   data_next;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic signed [31:0]     step;

    assign ready_o = !valid_reg || ready_i;
    assign valid_o = valid_reg;
    assign data_o  = data_reg;

    // One micro-rotation, its direction set by the sign of the residual angle.
    assign dx   = data_i.x >>> IDX;
    assign dy   = data_i.y >>> IDX;
    assign step = $signed(ATAN_TURN[IDX]);

    always_comb begin
        if (!data_i.z[31]) begin
            data_next.x = data_i.x - dy;
            data_next.y = data_i.y + dx;
            data_next.z = data_i.z - step;
        end else begin
            data_next.x = data_i.x + dy;
            data_next.y = data_i.y - dx;
            data_next.z = data_i.z + step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/core/vrba_back.sv @@
module vrba_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               valid_i,
    input  vrba_pkg::xyz_t     data_i,
    output logic               ready_o,
    output logic               valid_o,
    output logic signed [31:0] x_out,
    output logic signed [31:0] y_out,
    output logic               saturated,
    input  logic               ready_i
);
    import vrba_pkg::*;

    localparam logic signed [XY_W-1:0] ROUND_OUT = XY_W'(1 << (GUARD - 1));
    localparam logic signed [XY_W-1:0] MAX_V = {{(XY_W - 32){1'b0}}, 32'h7FFF_FFFF};
    localparam logic signed [XY_W-1:0] MIN_V = {{(XY_W - 32){1'b1}}, 32'h8000_0000};

    logic                   valid_reg;
    logic signed [31:0]     x_reg;
    logic signed [31:0]     y_reg;
    logic                   sat_reg;
    logic signed [XY_W-1:0] xr;
    logic signed [XY_W-1:0] yr;
    logic signed [31:0]     x_next;
    logic signed [31:0]     y_next;
    logic                   x_clip;
    logic                   y_clip;

    assign ready_o   = !valid_reg || ready_i;
    assign valid_o   = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign saturated = sat_reg;

    // Drop the guard bits with rounding.
    assign xr = (data_i.x + ROUND_OUT) >>> GUARD;
    assign yr = (data_i.y + ROUND_OUT) >>> GUARD;

    // Clip each component to the 32-bit signed range.
    always_comb begin
        x_clip = 1'b1;
        y_clip = 1'b1;
        priority if (xr > MAX_V) begin
            x_next = 32'sh7FFF_FFFF;
        end else if (xr < MIN_V) begin
            x_next = 32'sh8000_0000;
        end else begin
            x_next = xr[31:0];
            x_clip = 1'b0;
        end
        priority if (yr > MAX_V) begin
            y_next = 32'sh7FFF_FFFF;
        end else if (yr < MIN_V) begin
            y_next = 32'sh8000_0000;
        end else begin
            y_next = yr[31:0];
            y_clip = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            sat_reg <= x_clip || y_clip;
        end
    end

endmodule

@@ rtl/core/vector_rotate_by_angle.sv @@
// Channel   Direction  tdata (low bit up)           tuser
// s_        in         x_in, y_in, angle (96 bits)  angle_in_radians
// m_        out        x_out, y_out (64 bits)       saturated
//
// Five front stages (two partial products of the angle scaling, phase rounding,
// quadrant fold, gain multiply, guard rounding), one cell per CORDIC iteration, and
// the rounding and saturating output register form the pipeline. One transfer is
// taken per cycle unless m_tready stalls; the rate is set by the registered cell chain.
// Reset clears only the valid bits; the pipeline is empty afterwards.
// Every stage moves forward when its successor is empty or moving, so bubbles collapse
// and s_tready stays high while a result waits on m_tready with room left upstream.
module vector_rotate_by_angle #(
    parameter int ITERATIONS = vrba_pkg::DEF_ITERATIONS,
    parameter int FRAC_BITS  = vrba_pkg::DEF_FRAC_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // x_in [31:0], y_in [63:32], angle [95:64]
    input  logic        s_tuser,   // angle_in_radians
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // x_out [31:0], y_out [63:32]
    output logic        m_tuser    // saturated
);
    import vrba_pkg::*;

    logic [ITERATIONS:0] chain_valid;
    logic [ITERATIONS:0] chain_ready;
    xyz_t                chain_data [ITERATIONS+1];
    logic signed [31:0]  x_out;
    logic signed [31:0]  y_out;

    // Angle scaling, quadrant fold and gain compensation.
    vrba_front #(
        .ITERATIONS (ITERATIONS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .valid_i          (s_tvalid),
        .x_in             ($signed(s_tdata[31:0])),
        .y_in             ($signed(s_tdata[63:32])),
        .angle            ($signed(s_tdata[95:64])),
        .angle_in_radians (s_tuser),
        .ready_o          (s_tready),
        .valid_o          (chain_valid[0]),
        .data_o           (chain_data[0]),
        .ready_i          (chain_ready[0])
    );

    // One cell per CORDIC iteration.
    for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
        vrba_cell #(
            .SHIFT (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .valid_i (chain_valid[i]),
            .data_i  (chain_data[i]),
            .ready_o (chain_ready[i]),
            .valid_o (chain_valid[i+1]),
            .data_o  (chain_data[i+1]),
            .ready_i (chain_ready[i+1])
        );
    end

    // Output rounding, saturation and result register.
    vrba_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .valid_i   (chain_valid[ITERATIONS]),
        .data_i    (chain_data[ITERATIONS]),
        .ready_o   (chain_ready[ITERATIONS]),
        .valid_o   (m_tvalid),
        .x_out     (x_out),
        .y_out     (y_out),
        .saturated (m_tuser),
        .ready_i   (m_tready)
    );

    assign m_tdata = {y_out, x_out};

    // A clipped result always sits on a range bound.
    a_sat_on_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            x_out == 32'sh7FFF_FFFF || x_out == 32'sh8000_0000 ||
            y_out == 32'sh7FFF_FFFF || y_out == 32'sh8000_0000)
        else $error("saturated flag set without a clipped component");

    // Input back-pressure only arises from a stalled, full pipeline.
    a_ready_only_when_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready && (&chain_valid))
        else $error("input stalled while the pipeline has room");

    // Reset empties the output register.
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule
